[hdl/jued_pkg.sv]
// jued_pkg: shared types, character codes and helpers for the json unicode escape decoder
// no dependencies; imported by every module of the decoder
package jued_pkg;

    // one input request and one output request
    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_last;
    } out_item_t;

    // most bytes a single input character can release
    localparam int RUN_MAX   = 6;
    localparam int RUN_CNT_W = 3;
    localparam int RUN_IDX_W = 3;

    // run of output bytes caused by one input character
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [RUN_CNT_W-1:0]    count;
        logic                    eos;
    } run_t;

    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_U      = 8'h75;

    // utf-8 boundaries and lead/continuation marks
    localparam logic [15:0] UTF8_ONE_LIMIT = 16'h0080;
    localparam logic [15:0] UTF8_TWO_LIMIT = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
    localparam logic [7:0]  UTF8_CONT      = 8'h80;
    localparam logic [5:0]  UTF8_CONT_MASK = 6'h3F;

    function automatic logic hex_ok(input logic [7:0] c);
        logic ok;
        ok = ((c >= 8'h30) && (c <= 8'h39)) ||
             ((c >= 8'h61) && (c <= 8'h66)) ||
             ((c >= 8'h41) && (c <= 8'h46));
        return ok;
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        if ((c >= 8'h61) && (c <= 8'h66)) begin
            d = c - 8'h57;
        end else if ((c >= 8'h41) && (c <= 8'h46)) begin
            d = c - 8'h37;
        end else begin
            d = c - 8'h30;
        end
        return d[3:0];
    endfunction

endpackage

[hdl/jued_front.sv]
// jued_front: escape tracker that turns each input character into a run of output bytes
// depends on jued_pkg
module jued_front
    import jued_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_take,
    input  in_item_t in_item,
    output logic     run_valid,
    output run_t     run_out
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_BSLASH = 3'd1;
    localparam logic [2:0] PH_U      = 3'd2;
    localparam logic [2:0] PH_D1     = 3'd3;
    localparam logic [2:0] PH_D2     = 3'd4;
    localparam logic [2:0] PH_D3     = 3'd5;

    logic [2:0]       phase_reg, phase_next;
    logic [11:0]      acc_reg, acc_next;
    logic [2:0][7:0]  digit_reg;

    logic [7:0]       c;
    logic             eos;
    logic             is_hex;
    logic [3:0]       v;
    logic             cont, complete, start, store_digit;
    logic [2:0]       held_len;
    logic [4:0][7:0]  held;
    logic [15:0]      cp;

    assign c      = in_item.in_char;
    assign eos    = in_item.end_of_string;
    assign is_hex = hex_ok(c);
    assign v      = hex_val(c);
    assign cp     = {acc_reg, v};

    assign held = {digit_reg[2], digit_reg[1], digit_reg[0], CHAR_U, CHAR_BSLASH};

    always_comb begin
        cont = 1'b0;
        case (phase_reg)
            PH_BSLASH:         cont = (c == CHAR_U);
            PH_U, PH_D1, PH_D2: cont = is_hex;
            default:           cont = 1'b0;
        endcase
    end

    assign complete    = (phase_reg == PH_D3) && is_hex;
    assign start       = (c == CHAR_BSLASH) && !eos;
    assign held_len    = ((phase_reg >= PH_BSLASH) && (phase_reg <= PH_D3)) ? phase_reg : PH_IDLE;
    assign store_digit = cont && !eos && (phase_reg != PH_BSLASH);

    always_comb begin
        run_out       = '0;
        run_out.eos   = eos;
        phase_next    = PH_IDLE;
        acc_next      = acc_reg;
        if (complete) begin
            acc_next = '0;
            if (cp < UTF8_ONE_LIMIT) begin
                run_out.bytes[0] = cp[7:0];
                run_out.count    = 3'd1;
            end else if (cp < UTF8_TWO_LIMIT) begin
                run_out.bytes[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
                run_out.bytes[1] = UTF8_CONT | {2'b00, cp[5:0] & UTF8_CONT_MASK};
                run_out.count    = 3'd2;
            end else begin
                run_out.bytes[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
                run_out.bytes[1] = UTF8_CONT | {2'b00, cp[11:6] & UTF8_CONT_MASK};
                run_out.bytes[2] = UTF8_CONT | {2'b00, cp[5:0] & UTF8_CONT_MASK};
                run_out.count    = 3'd3;
            end
        end else if (cont && !eos) begin
            // escape grows by one character, nothing released yet
            phase_next = phase_reg + 3'd1;
            acc_next   = (phase_reg == PH_BSLASH) ? 12'd0 : {acc_reg[7:0], v};
        end else begin
            // release whatever is held, then the character itself unless it opens an escape
            for (int i = 0; i < RUN_MAX - 1; i++) begin
                run_out.bytes[i] = (3'(i) < held_len) ? held[i] : c;
            end
            run_out.bytes[RUN_MAX-1] = c;
            run_out.count = held_len + {2'b00, !start};
            phase_next    = start ? PH_BSLASH : PH_IDLE;
            if (eos) begin
                acc_next = '0;
            end
        end
    end

    assign run_valid = in_take && (run_out.count != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            acc_reg   <= '0;
        end else if (in_take) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
        end
    end

    // raw digits kept for a possible broken escape
    always_ff @(posedge aclk) begin
        if (in_take && store_digit) begin
            for (int k = 0; k < 3; k++) begin
                if (phase_reg == PH_U + 3'(k)) begin
                    digit_reg[k] <= c;
                end
            end
        end
    end

endmodule

[hdl/jued_queue.sv]
// jued_queue: short fifo of byte runs between the front and back of the decoder
// depends on jued_pkg
module jued_queue
    import jued_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  run_t push_run,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output run_t head_run
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    run_t             mem [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [IDX_W-1:0] bump(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] n;
        n = (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
        return n;
    endfunction

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_run   = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_run;
        end
    end

endmodule

[hdl/jued_back.sv]
// jued_back: serializes queued byte runs into single output requests
// depends on jued_pkg
module jued_back
    import jued_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      head_valid,
    input  run_t      head_run,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic [RUN_IDX_W-1:0] idx_reg, idx_next;
    logic                 m_valid_reg;
    out_item_t            m_item_reg, m_item_next;
    logic                 load, last;

    assign load = head_valid && (!m_valid_reg || m_ready);
    assign last = (idx_reg == head_run.count - 1'b1);
    assign pop  = load && last;

    assign idx_next = last ? '0 : idx_reg + 1'b1;

    always_comb begin
        m_item_next.out_byte    = head_run.bytes[idx_reg];
        m_item_next.run_last    = last;
        m_item_next.stream_last = last && head_run.eos;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                idx_reg     <= idx_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

[hdl/json_unicode_escape_decoder_core.sv]
// json_unicode_escape_decoder_core: top level of the \uXXXX escape to utf-8 decoder
// depends on jued_pkg, jued_front, jued_queue, jued_back
//
// usage
//   s_ channel: one request per text character (in_char, end_of_string)
//   m_ channel: one request per output byte (out_byte, run_last, stream_last)
//   plain characters pass through; a backslash, 'u' and four hex digits become
//   the 1 to 3 byte utf-8 form of the code point; a broken or cut-short escape
//   comes out raw, and one character can release up to six bytes
//   run_last marks the last byte an input character caused, stream_last the
//   last byte of a string; characters that only extend an escape release nothing
// timing
//   a taken character's run enters the queue, then its bytes the output register
//   input: one character per cycle while the run queue has room
//   output: one byte per cycle while m_ready is high; the input rate is bounded
//   by the byte rate over time; the QUEUE_DEPTH entry queue absorbs multi-byte runs
// reset
//   synchronous active-low aresetn empties the queue, drops m_valid and returns
//   the escape tracker to plain copying
// stalls
//   with m_ready low the byte on m_ holds; runs pile up in the queue and s_ready
//   falls only once all QUEUE_DEPTH entries are taken
module json_unicode_escape_decoder_core
    import jued_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic in_take;
    logic run_valid;
    run_t run_front;
    logic q_full;
    logic q_pop;
    logic q_head_valid;
    run_t q_head;

    // accept whenever the queue has a free entry
    assign s_ready = !q_full;
    assign in_take = s_valid && s_ready;

    // front: escape tracking and byte run building
    jued_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_take   (in_take),
        .in_item   (s_item),
        .run_valid (run_valid),
        .run_out   (run_front)
    );

    // queue: decouples character intake from byte output
    jued_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (run_valid),
        .push_run   (run_front),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_run   (q_head)
    );

    // back: one byte per cycle into the output register unless the output is stalled
    jued_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_run   (q_head),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule

[hdl/jued_checker.sv]
// jued_checker: port-level checks for the json unicode escape decoder
// depends on jued_pkg; bound to json_unicode_escape_decoder_core
module jued_checker
    import jued_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_item,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // no output left over from before reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("output valid or input stalled right after reset");

    // a waiting input request holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_item))
        else $error("input request changed while waiting");

    // a stalled output request holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("output request changed while stalled");

    // end of string only on the closing byte of a run
    a_stream_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_item.stream_last || m_item.run_last))
        else $error("stream_last without run_last");

    // input only backs up behind a pending output byte
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no output pending");

endmodule

bind json_unicode_escape_decoder_core jued_checker u_jued_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
